// ----- rtl/core/murm_pkg.sv -----
// Shared package for the MurmurHash3 x64_128 chained hash unit.
// Holds the hash constants, the multiplier phase and sequencer state types
// and small helpers. It depends on nothing else.
`default_nettype none

package murm_pkg;

    // Body scrambling constants.
    localparam logic [63:0] MIX_C1  = 64'h87c3_7b91_1142_53d5;
    localparam logic [63:0] MIX_C2  = 64'h4cf5_ad43_2745_937f;
    localparam logic [63:0] ADD_H1  = 64'h0000_0000_52dc_e729;
    localparam logic [63:0] ADD_H2  = 64'h0000_0000_3849_5ab5;

    // Finaliser constants.
    localparam logic [63:0] FMIX_M1 = 64'hff51_afd7_ed55_8ccd;
    localparam logic [63:0] FMIX_M2 = 64'hc4ce_b9fe_1a85_ec53;

    // Golden-ratio constant of the combine fold.
    localparam logic [63:0] GOLDEN  = 64'h0000_0000_9e37_79b9;

    // Bytes in one chunk.
    localparam logic [4:0]  CHUNK_BYTES = 5'd16;

    // Stream widths.
    localparam int unsigned S_TDATA_W = 136;
    localparam int unsigned M_TDATA_W = 192;

    // Phases of the shared multiplier: low x low, low x high, high x low.
    typedef enum logic [3:0] {
        MUL_IDLE = 4'b0001,
        MUL_LL   = 4'b0010,
        MUL_LH   = 4'b0100,
        MUL_HL   = 4'b1000
    } mul_phase_t;

    // Handshake between the sequencer and the shared multiplier.
    typedef struct packed {
        logic        start;
        logic [63:0] op_a;
        logic [63:0] op_b;
    } mul_req_t;

    typedef struct packed {
        logic        done;
        logic [63:0] product;
    } mul_rsp_t;

    // Sequencer states of the hash engine.
    typedef enum logic [12:0] {
        ST_IDLE = 13'b0_0000_0000_0001,
        ST_K1A  = 13'b0_0000_0000_0010,
        ST_K1B  = 13'b0_0000_0000_0100,
        ST_K2A  = 13'b0_0000_0000_1000,
        ST_K2B  = 13'b0_0000_0001_0000,
        ST_FOLD = 13'b0_0000_0010_0000,
        ST_FM1A = 13'b0_0000_0100_0000,
        ST_FM1B = 13'b0_0000_1000_0000,
        ST_FM2A = 13'b0_0001_0000_0000,
        ST_FM2B = 13'b0_0010_0000_0000,
        ST_ADD1 = 13'b0_0100_0000_0000,
        ST_ADD2 = 13'b0_1000_0000_0000,
        ST_EMIT = 13'b1_0000_0000_0000
    } seq_state_t;

    // Keeps the lowest n bytes of a word; n of eight or more keeps all.
    function automatic logic [63:0] keep_bytes(input logic [63:0] v, input logic [4:0] n);
        logic [63:0] r;
        r = '0;
        for (int i = 0; i < 8; i++) begin
            if (5'(i) < n) begin
                r[i*8 +: 8] = v[i*8 +: 8];
            end
        end
        return r;
    endfunction

    // The xor-shift step of the finaliser.
    function automatic logic [63:0] xsh33(input logic [63:0] v);
        return v ^ (v >> 33);
    endfunction

endpackage : murm_pkg

`default_nettype wire

// ----- rtl/core/murm_mul64.sv -----
// Shared 64 x 64 multiplier keeping the low 64 bits of the product.
// One 32 x 32 multiplier is used in three steps; depends on murm_pkg.
`default_nettype none

module murm_mul64
    import murm_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire mul_req_t req,
    output mul_rsp_t      rsp
);

    mul_phase_t  phase_reg, phase_next;
    logic [63:0] a_reg, b_reg;
    logic [63:0] acc_reg, acc_next;
    logic        done_reg, done_next;
    logic [31:0] mul_x, mul_y;
    logic [63:0] part;

    // Only the cross terms whose low halves land in the upper word matter.
    always_comb begin
        mul_x = a_reg[31:0];
        mul_y = b_reg[31:0];
        if (phase_reg == MUL_LH) begin
            mul_y = b_reg[63:32];
        end else if (phase_reg == MUL_HL) begin
            mul_x = a_reg[63:32];
        end
        part = {32'd0, mul_x} * {32'd0, mul_y};
    end

    always_comb begin
        phase_next = phase_reg;
        acc_next   = acc_reg;
        done_next  = 1'b0;
        unique case (phase_reg)
            MUL_IDLE: begin
                if (req.start) begin
                    phase_next = MUL_LL;
                end
            end
            MUL_LL: begin
                acc_next   = part;
                phase_next = MUL_LH;
            end
            MUL_LH: begin
                acc_next   = {acc_reg[63:32] + part[31:0], acc_reg[31:0]};
                phase_next = MUL_HL;
            end
            MUL_HL: begin
                acc_next   = {acc_reg[63:32] + part[31:0], acc_reg[31:0]};
                done_next  = 1'b1;
                phase_next = MUL_IDLE;
            end
            default: begin
                phase_next = MUL_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= MUL_IDLE;
            done_reg  <= 1'b0;
        end else begin
            phase_reg <= phase_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        acc_reg <= acc_next;
        if (phase_reg == MUL_IDLE && req.start) begin
            a_reg <= req.op_a;
            b_reg <= req.op_b;
        end
    end

    assign rsp.done    = done_reg;
    assign rsp.product = acc_reg;

endmodule : murm_mul64

`default_nettype wire

// ----- rtl/core/murmur3_128_chained_hash_unit.sv -----
// Top level of the MurmurHash3 x64_128 chained hash unit: stream ports,
// sequencer, lane state and output register. Depends on murm_pkg and murm_mul64.
`default_nettype none

// This unit hashes a message fed as 16-byte chunks, little-endian, with the
// MurmurHash3 x64_128 algorithm. The lanes carry over from one message to
// the next; an item with tuser set clears both lanes and the byte count
// before it is processed. Every chunk that is not marked with tlast counts
// as a full block whatever its count. The chunk marked with tlast may carry
// 0 to 16 bytes (larger counts are taken as 16, bytes above the count are
// ignored); it mixes the tail, folds in the message length modulo 2^64, runs
// fmix64 on both lanes and produces one result item holding both lanes and
// the golden-ratio combine fold. All 64-bit products come from a single
// shared multiplier built around one 32 x 32 array. An item is processed
// entirely before the next is taken: a chunk that is not final needs four
// products, a full final chunk eight products plus folding and combine
// steps, and a partial final chunk between four and eight products
// depending on how many tail words it holds. The result sits in an output
// register, so the next item is accepted while an earlier result still
// waits for m_tready.
module murmur3_128_chained_hash_unit
    import murm_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    // Input items.
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    // data_low [63:0], data_high [127:64], byte_count [132:128], zero pad above.
    input  wire logic [S_TDATA_W-1:0]  s_tdata,
    // final_chunk.
    input  wire logic                  s_tlast,
    // restart.
    input  wire logic                  s_tuser,
    // Result items.
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    // hash_lane_one [63:0], hash_lane_two [127:64], folded_hash [191:128].
    output logic [M_TDATA_W-1:0]       m_tdata
);

    seq_state_t  state_reg, state_next;
    logic        issued_reg, issued_next;
    logic [63:0] h1_reg, h1_next;
    logic [63:0] h2_reg, h2_next;
    logic [63:0] msg_reg, msg_next;
    logic [63:0] v_reg, v_next;
    logic [63:0] t_reg, t_next;
    logic [63:0] lo_reg, hi_reg;
    logic [4:0]  cnt_reg;
    logic        fin_reg;
    logic        body_reg;
    logic        m_valid_reg, m_valid_next;
    logic [M_TDATA_W-1:0] m_data_reg;

    logic        accept;
    logic        out_free;
    logic [4:0]  in_cnt;
    logic        in_fin;
    logic        in_body;
    logic [63:0] in_lo, in_hi;
    logic [63:0] k, x, len, f1, f2;
    logic        is_mul_state;
    logic        load_out;
    mul_req_t    mreq;
    mul_rsp_t    mrsp;

    murm_mul64 u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (mreq),
        .rsp     (mrsp)
    );

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;

    // Decode of the incoming chunk: saturate the count and mask a partial tail.
    always_comb begin
        in_fin  = s_tlast;
        in_cnt  = (s_tdata[132:128] > CHUNK_BYTES) ? CHUNK_BYTES : s_tdata[132:128];
        in_body = !in_fin || (in_cnt == CHUNK_BYTES);
        in_lo   = s_tdata[63:0];
        in_hi   = s_tdata[127:64];
        if (!in_body) begin
            in_lo = keep_bytes(s_tdata[63:0], in_cnt);
            in_hi = (in_cnt > 5'd8) ? keep_bytes(s_tdata[127:64], in_cnt - 5'd8) : 64'd0;
        end
    end

    // Operands offered to the shared multiplier in each product state.
    always_comb begin
        is_mul_state = 1'b1;
        mreq.op_a    = lo_reg;
        mreq.op_b    = MIX_C1;
        unique case (state_reg)
            ST_K1A: begin
                mreq.op_a = lo_reg;
                mreq.op_b = MIX_C1;
            end
            ST_K1B: begin
                mreq.op_a = {v_reg[32:0], v_reg[63:33]};
                mreq.op_b = MIX_C2;
            end
            ST_K2A: begin
                mreq.op_a = hi_reg;
                mreq.op_b = MIX_C2;
            end
            ST_K2B: begin
                mreq.op_a = {v_reg[30:0], v_reg[63:31]};
                mreq.op_b = MIX_C1;
            end
            ST_FM1A: begin
                mreq.op_a = xsh33(h1_reg);
                mreq.op_b = FMIX_M1;
            end
            ST_FM1B: begin
                mreq.op_a = xsh33(v_reg);
                mreq.op_b = FMIX_M2;
            end
            ST_FM2A: begin
                mreq.op_a = xsh33(h2_reg);
                mreq.op_b = FMIX_M1;
            end
            ST_FM2B: begin
                mreq.op_a = xsh33(v_reg);
                mreq.op_b = FMIX_M2;
            end
            default: begin
                is_mul_state = 1'b0;
            end
        endcase
        mreq.start = is_mul_state && !issued_reg;
    end

    // Sequencer and lane updates.
    always_comb begin
        state_next   = state_reg;
        issued_next  = issued_reg;
        h1_next      = h1_reg;
        h2_next      = h2_reg;
        msg_next     = msg_reg;
        v_next       = v_reg;
        t_next       = t_reg;
        m_valid_next = m_valid_reg;
        load_out     = 1'b0;
        k            = mrsp.product;
        x            = '0;
        len          = msg_reg + {59'd0, cnt_reg};
        f1           = '0;
        f2           = '0;

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end
        if (mreq.start) begin
            issued_next = 1'b1;
        end
        if (mrsp.done) begin
            issued_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    // A restart clears the running state before this chunk.
                    if (s_tuser) begin
                        h1_next  = '0;
                        h2_next  = '0;
                        msg_next = '0;
                    end
                    if (in_body || in_cnt != 5'd0) begin
                        state_next = ST_K1A;
                    end else begin
                        state_next = ST_FOLD;
                    end
                end
            end
            ST_K1A: begin
                if (mrsp.done) begin
                    v_next     = mrsp.product;
                    state_next = ST_K1B;
                end
            end
            ST_K1B: begin
                if (mrsp.done) begin
                    if (body_reg) begin
                        x       = h1_reg ^ k;
                        x       = {x[36:0], x[63:37]} + h2_reg;
                        h1_next = (x << 2) + x + ADD_H1;
                    end else begin
                        h1_next = h1_reg ^ k;
                    end
                    if (body_reg || cnt_reg > 5'd8) begin
                        state_next = ST_K2A;
                    end else begin
                        state_next = ST_FOLD;
                    end
                end
            end
            ST_K2A: begin
                if (mrsp.done) begin
                    v_next     = mrsp.product;
                    state_next = ST_K2B;
                end
            end
            ST_K2B: begin
                if (mrsp.done) begin
                    if (body_reg) begin
                        x       = h2_reg ^ k;
                        x       = {x[32:0], x[63:33]} + h1_reg;
                        h2_next = (x << 2) + x + ADD_H2;
                    end else begin
                        h2_next = h2_reg ^ k;
                    end
                    if (fin_reg) begin
                        state_next = ST_FOLD;
                    end else begin
                        msg_next   = msg_reg + {59'd0, CHUNK_BYTES};
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_FOLD: begin
                // Length fold and both cross-adds that precede fmix64.
                f1         = (h1_reg ^ len) + (h2_reg ^ len);
                f2         = (h2_reg ^ len) + f1;
                h1_next    = f1;
                h2_next    = f2;
                msg_next   = '0;
                state_next = ST_FM1A;
            end
            ST_FM1A: begin
                if (mrsp.done) begin
                    v_next     = mrsp.product;
                    state_next = ST_FM1B;
                end
            end
            ST_FM1B: begin
                if (mrsp.done) begin
                    h1_next    = xsh33(mrsp.product);
                    state_next = ST_FM2A;
                end
            end
            ST_FM2A: begin
                if (mrsp.done) begin
                    v_next     = mrsp.product;
                    state_next = ST_FM2B;
                end
            end
            ST_FM2B: begin
                if (mrsp.done) begin
                    h2_next    = xsh33(mrsp.product);
                    state_next = ST_ADD1;
                end
            end
            ST_ADD1: begin
                h1_next    = h1_reg + h2_reg;
                state_next = ST_ADD2;
            end
            ST_ADD2: begin
                // Lane one is final here, so its share of the fold can be formed.
                h2_next    = h2_reg + h1_reg;
                t_next     = GOLDEN + (h1_reg << 6) + (h1_reg >> 2);
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (out_free) begin
                    load_out     = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            issued_reg  <= 1'b0;
            h1_reg      <= '0;
            h2_reg      <= '0;
            msg_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            issued_reg  <= issued_next;
            h1_reg      <= h1_next;
            h2_reg      <= h2_next;
            msg_reg     <= msg_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        v_reg <= v_next;
        t_reg <= t_next;
        if (accept) begin
            lo_reg   <= in_lo;
            hi_reg   <= in_hi;
            cnt_reg  <= in_cnt;
            fin_reg  <= in_fin;
            body_reg <= in_body;
        end
        if (load_out) begin
            m_data_reg <= {h1_reg ^ (h2_reg + t_reg), h2_reg, h1_reg};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule : murmur3_128_chained_hash_unit

`default_nettype wire
